>>> rtl/core/hrvs_pkg.sv
// Shared constants and result type for the heart rate variability statistics unit
package hrvs_pkg;

	localparam int RR_W        = 16;
	localparam int THR_W       = 11;
	localparam int ROOT_W      = 20;
	localparam int PNN_W       = 14;
	localparam int CNT_OUT_W   = 11;
	localparam int PNN_SCALE   = 10000;
	localparam int DIV_W       = 72;
	localparam int RAD_W       = 2 * ROOT_W;
	localparam int STEP_W      = 7;
	localparam int ACC_W       = 64;
	localparam int FRAC_SH     = 8;
	localparam int TDATA_IN_W  = 16;
	localparam int TDATA_OUT_W = 72;
	localparam logic [THR_W-1:0] THR_RESET = 11'd50;

	typedef struct packed {
		logic                 overflow;
		logic [CNT_OUT_W-1:0] beat_count;
		logic [PNN_W-1:0]     pnn50_bp;
		logic [ROOT_W-1:0]    sdnn_q4;
		logic [ROOT_W-1:0]    rmssd_q4;
	} res_t;

endpackage

>>> rtl/core/hrvs_fifo.sv
// Two-entry job queue between the accumulating front and the arithmetic back
module hrvs_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end
endmodule

>>> rtl/core/hrvs_front.sv
// Front: takes RR words, keeps the running sums and queues one job per run
module hrvs_front #(
	parameter int MAX_BEATS = 1024,
	localparam int CW  = $clog2(MAX_BEATS + 1),
	localparam int S1W = hrvs_pkg::RR_W + CW,
	localparam int S2W = 2 * hrvs_pkg::RR_W + CW,
	localparam int JW  = 2 * CW + S1W + 2 * S2W + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [hrvs_pkg::THR_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [hrvs_pkg::RR_W-1:0]  rr,
	input  logic                       last_in,
	input  logic                       job_full,
	output logic                       job_push,
	output logic [JW-1:0]              job_data
);
	import hrvs_pkg::*;

	logic [THR_W-1:0]  thr_q;
	logic [RR_W-1:0]   prev_q;
	logic [CW-1:0]     cnt_q;
	logic [S1W-1:0]    s1_q;
	logic [S2W-1:0]    s2_q;
	logic [S2W-1:0]    d_q;
	logic [CW-1:0]     big_q;
	logic              drop_q;

	logic              at_cap;
	logic              accept;
	logic [RR_W-1:0]   mag;
	logic [2*RR_W-1:0] mag_sq;
	logic [2*RR_W-1:0] rr_sq;
	logic              big_hit;
	logic [CW-1:0]     cnt_d;
	logic [S1W-1:0]    s1_d;
	logic [S2W-1:0]    s2_d;
	logic [S2W-1:0]    d_d;
	logic [CW-1:0]     big_d;
	logic              drop_d;

	assign in_ready = !job_full;
	assign accept   = in_valid && in_ready;
	assign at_cap   = (cnt_q == CW'(MAX_BEATS));
	assign mag      = (rr >= prev_q) ? rr - prev_q : prev_q - rr;
	assign mag_sq   = mag * mag;
	assign rr_sq    = rr * rr;
	assign big_hit  = (cnt_q != '0) && (mag > RR_W'(thr_q));

	always_comb begin
		cnt_d  = cnt_q;
		s1_d   = s1_q;
		s2_d   = s2_q;
		d_d    = d_q;
		big_d  = big_q;
		drop_d = drop_q | at_cap;
		if (!at_cap) begin
			cnt_d = cnt_q + CW'(1);
			s1_d  = s1_q + S1W'(rr);
			s2_d  = s2_q + S2W'(rr_sq);
			if (cnt_q != '0) begin
				d_d = d_q + S2W'(mag_sq);
			end
			if (big_hit) begin
				big_d = big_q + CW'(1);
			end
		end
	end

	assign job_push = accept && last_in;
	assign job_data = {drop_d, big_d, d_d, s2_d, s1_d, cnt_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			prev_q <= '0;
			cnt_q  <= '0;
			s1_q   <= '0;
			s2_q   <= '0;
			d_q    <= '0;
			big_q  <= '0;
			drop_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (accept) begin
				if (last_in) begin
					prev_q <= '0;
					cnt_q  <= '0;
					s1_q   <= '0;
					s2_q   <= '0;
					d_q    <= '0;
					big_q  <= '0;
					drop_q <= 1'b0;
				end else begin
					if (!at_cap) begin
						prev_q <= rr;
					end
					cnt_q  <= cnt_d;
					s1_q   <= s1_d;
					s2_q   <= s2_d;
					d_q    <= d_d;
					big_q  <= big_d;
					drop_q <= drop_d;
				end
			end
		end
	end
endmodule

>>> rtl/core/hrvs_back.sv
// Back: serial multiplies, restoring divides and bitwise roots for one run's result
module hrvs_back #(
	parameter int MAX_BEATS = 1024,
	localparam int CW  = $clog2(MAX_BEATS + 1),
	localparam int S1W = hrvs_pkg::RR_W + CW,
	localparam int S2W = 2 * hrvs_pkg::RR_W + CW,
	localparam int JW  = 2 * CW + S1W + 2 * S2W + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_empty,
	input  logic [JW-1:0]         job_data,
	output logic                  job_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  out_flag,
	output hrvs_pkg::res_t        out_res
);
	import hrvs_pkg::*;

	localparam int DW = 2 * CW;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_DIVD  = 9'b000000010,
		ST_ROOTD = 9'b000000100,
		ST_MULA  = 9'b000001000,
		ST_MULB  = 9'b000010000,
		ST_DIVV  = 9'b000100000,
		ST_ROOTV = 9'b001000000,
		ST_DIVP  = 9'b010000000,
		ST_HOLD  = 9'b100000000
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic [CW-1:0]     n_q;
	logic [S1W-1:0]    s1_q;
	logic [CW-1:0]     big_q;
	logic              drop_q;
	logic [ACC_W-1:0]  ma_q;
	logic [S1W-1:0]    mb_q;
	logic [ACC_W-1:0]  acc_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     den_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] k_q;
	logic [ROOT_W-1:0] rmssd_q;
	logic [ROOT_W-1:0] sdnn_q;
	logic              out_valid_q;
	logic              out_flag_q;
	res_t              out_q;

	logic [CW-1:0]        j_n;
	logic [S1W-1:0]       j_s1;
	logic [S2W-1:0]       j_s2;
	logic [S2W-1:0]       j_d;
	logic [CW-1:0]        j_big;
	logic                 j_drop;
	logic [DW:0]          rem_sh;
	logic                 ge;
	logic [DW-1:0]        rem_nx;
	logic [DIV_W-1:0]     quo_nx;
	logic [RAD_W-1:0]     rad_nx;
	logic [4:0]           bit_idx;
	logic [ROOT_W-1:0]    cand;
	logic [RAD_W-1:0]     cand_sq;
	logic [ROOT_W-1:0]    k_nx;
	logic [ACC_W-1:0]     acc_add;
	logic [ACC_W-1:0]     acc_sub;
	logic [DW-1:0]        nn;
	logic [CW+PNN_W-1:0]  pnn_num;
	logic                 div_last;
	logic                 root_last;
	logic                 mul_last;
	logic                 out_free;

	assign {j_drop, j_big, j_d, j_s2, j_s1, j_n} = job_data;

	assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
	assign ge      = (rem_sh >= {1'b0, den_q});
	assign rem_nx  = ge ? DW'(rem_sh - {1'b0, den_q}) : DW'(rem_sh);
	assign quo_nx  = {quo_q[DIV_W-2:0], ge};
	assign rad_nx  = (|quo_nx[DIV_W-1:RAD_W]) ? '1 : quo_nx[RAD_W-1:0];

	assign bit_idx = 5'(ROOT_W - 1) - step_q[4:0];
	assign cand    = k_q | (ROOT_W'(1) << bit_idx);
	assign cand_sq = cand * cand;
	assign k_nx    = (cand_sq <= rad_q) ? cand : k_q;

	assign acc_add = mb_q[0] ? acc_q + ma_q : acc_q;
	assign acc_sub = mb_q[0] ? acc_q - ma_q : acc_q;
	assign nn      = n_q * n_q;
	assign pnn_num = big_q * PNN_W'(PNN_SCALE);

	assign div_last  = (step_q == STEP_W'(DIV_W - 1));
	assign root_last = (step_q == STEP_W'(ROOT_W - 1));
	assign mul_last  = (step_q == STEP_W'(S1W - 1));
	assign out_free  = !out_valid_q || out_ready;

	assign job_pop   = (state_q == ST_IDLE) && !job_empty;
	assign out_valid = out_valid_q;
	assign out_flag  = out_flag_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			n_q         <= '0;
			s1_q        <= '0;
			big_q       <= '0;
			drop_q      <= 1'b0;
			ma_q        <= '0;
			mb_q        <= '0;
			acc_q       <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			den_q       <= '0;
			rad_q       <= '0;
			k_q         <= '0;
			rmssd_q     <= '0;
			sdnn_q      <= '0;
			out_valid_q <= 1'b0;
			out_flag_q  <= 1'b0;
			out_q       <= '0;
		end else begin
			if ((state_q == ST_HOLD) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						n_q    <= j_n;
						s1_q   <= j_s1;
						ma_q   <= ACC_W'(j_s2);
						big_q  <= j_big;
						drop_q <= j_drop;
						step_q <= '0;
						rem_q  <= '0;
						den_q  <= DW'(j_n - CW'(1));
						if (j_n < CW'(2)) begin
							rmssd_q   <= '0;
							sdnn_q    <= '0;
							quo_q     <= '0;
							state_q   <= ST_HOLD;
						end else begin
							quo_q   <= DIV_W'({j_d, FRAC_SH'(0)});
							state_q <= ST_DIVD;
						end
					end
				end
				ST_DIVD, ST_DIVV, ST_DIVP: begin
					rem_q  <= rem_nx;
					quo_q  <= quo_nx;
					if (div_last) begin
						step_q <= '0;
						rad_q  <= rad_nx;
						k_q    <= '0;
						case (state_q)
							ST_DIVD: state_q <= ST_ROOTD;
							ST_DIVV: state_q <= ST_ROOTV;
							default: state_q <= ST_HOLD;
						endcase
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_ROOTD, ST_ROOTV: begin
					k_q    <= k_nx;
					if (root_last) begin
						step_q <= '0;
						if (state_q == ST_ROOTD) begin
							rmssd_q <= k_nx;
							mb_q    <= S1W'(n_q);
							acc_q   <= '0;
							state_q <= ST_MULA;
						end else begin
							sdnn_q  <= k_nx;
							quo_q   <= DIV_W'(pnn_num);
							rem_q   <= '0;
							den_q   <= DW'(n_q - CW'(1));
							state_q <= ST_DIVP;
						end
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_MULA: begin
					acc_q  <= acc_add;
					if (mul_last) begin
						step_q  <= '0;
						ma_q    <= ACC_W'(s1_q);
						mb_q    <= s1_q;
						state_q <= ST_MULB;
					end else begin
						ma_q   <= ma_q << 1;
						mb_q   <= mb_q >> 1;
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_MULB: begin
					acc_q  <= acc_sub;
					ma_q   <= ma_q << 1;
					mb_q   <= mb_q >> 1;
					if (mul_last) begin
						step_q  <= '0;
						quo_q   <= {acc_sub, FRAC_SH'(0)};
						rem_q   <= '0;
						den_q   <= nn;
						state_q <= ST_DIVV;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_flag_q       <= (n_q >= CW'(2));
						out_q.rmssd_q4   <= rmssd_q;
						out_q.sdnn_q4    <= sdnn_q;
						out_q.pnn50_bp   <= quo_q[PNN_W-1:0];
						out_q.beat_count <= CNT_OUT_W'(n_q);
						out_q.overflow   <= drop_q;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

>>> rtl/core/heart_rate_variability_stats_unit.sv
// Heart rate variability statistics unit: RMSSD, SDNN and pNN50 over one run of RR words
// Throughput: one RR word per cycle while the job queue is not full; a word with tlast enters a two-entry job queue.
// After tlast the back divides and roots for RMSSD, runs two serial multiplies, divides and roots
// for SDNN and divides for pNN50, using the one-bit-a-cycle divider; a short run skips to the result.
// The front keeps taking words while the queue has room; a full queue holds s_tready low.
// arst_n clears all sums, the queue and the result register; the threshold resets to 50.
module heart_rate_variability_stats_unit #(
	parameter int MAX_BEATS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hrvs_pkg::THR_W-1:0]       cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [hrvs_pkg::TDATA_IN_W-1:0]  s_tdata,   // rr_ms
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [hrvs_pkg::TDATA_OUT_W-1:0] m_tdata,   // rmssd_q4, sdnn_q4, pnn50_bp, beat_count, overflow
	output logic                             m_tuser    // valid_res
);
	import hrvs_pkg::*;

	localparam int CW  = $clog2(MAX_BEATS + 1);
	localparam int S1W = RR_W + CW;
	localparam int S2W = 2 * RR_W + CW;
	localparam int JW  = 2 * CW + S1W + 2 * S2W + 1;

	logic          job_push;
	logic          job_pop;
	logic          job_full;
	logic          job_empty;
	logic [JW-1:0] job_wdata;
	logic [JW-1:0] job_rdata;
	res_t          res;

	hrvs_front #(.MAX_BEATS(MAX_BEATS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.rr       (s_tdata[RR_W-1:0]),
		.last_in  (s_tlast),
		.job_full (job_full),
		.job_push (job_push),
		.job_data (job_wdata)
	);

	hrvs_fifo #(.W(JW)) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.wdata (job_wdata),
		.pop   (job_pop),
		.rdata (job_rdata),
		.full  (job_full),
		.empty (job_empty)
	);

	hrvs_back #(.MAX_BEATS(MAX_BEATS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_empty(job_empty),
		.job_data (job_rdata),
		.job_pop  (job_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_flag (m_tuser),
		.out_res  (res)
	);

	assign m_tdata = TDATA_OUT_W'(res);
endmodule

>>> rtl/core/hrvs_checker.sv
// Port-level checks for the heart rate variability statistics unit, bound to the top level
module hrvs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tuser
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[53:0] == 54'd0)
		else $error("short run gave non-zero statistics");

	a_pnn_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[53:40] <= 14'd10000)
		else $error("pNN50 above full scale");
endmodule

bind heart_rate_variability_stats_unit hrvs_checker u_hrvs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
